@@ rtl/core/cnc_pkg.sv @@
// Shared types and constants for the coordination number counter.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package cnc_pkg;

  localparam int MAX_COLUMNS_DEF = 8;
  localparam int COUNT_BITS_DEF  = 16;

  // Fixed field widths
  localparam int COORD_W  = 24;
  localparam int DELTA_W  = COORD_W + 1;
  localparam int SQ_W     = 2 * DELTA_W;
  localparam int CUTOFF_W = 52;
  localparam int TYPE_W   = 8;
  localparam int MASK_W   = 32;
  localparam int NCOL_W   = 4;
  localparam int COL_W    = 3;
  localparam int OCOUNT_W = 16;
  localparam int HIT_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_LO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_HI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_GRP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NBR_GRP     = 3'd5;

  typedef struct packed {
    logic [CUTOFF_W-1:0] cutoff_sq;
    logic [NCOL_W-1:0]   num_columns;
    logic [63:0]         type_lo_pack;
    logic [63:0]         type_hi_pack;
    logic [MASK_W-1:0]   center_group_bits;
    logic [MASK_W-1:0]   neighbor_group_bits;
  } cfg_t;

  // One classified pair: which columns it bumps, and whether it closes the atom
  typedef struct packed {
    logic [HIT_W-1:0] hits;
    logic             last;
  } pair_ent_t;

  // Columns in use: zero acts as one, anything above the maximum is clipped
  function automatic logic [NCOL_W-1:0] active_cols(input logic [NCOL_W-1:0] n,
                                                    input int maxc);
    logic [NCOL_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = NCOL_W'(1);
    end else if (n > NCOL_W'(maxc)) begin
      r = NCOL_W'(maxc);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/cnc_in_if.sv @@
// Input channel of the coordination number counter: one neighbor pair per transaction.
// Depends on cnc_pkg for field widths.
interface cnc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cnc_pkg::COORD_W-1:0]  center_x;
  logic signed [cnc_pkg::COORD_W-1:0]  center_y;
  logic signed [cnc_pkg::COORD_W-1:0]  center_z;
  logic signed [cnc_pkg::COORD_W-1:0]  nbr_x;
  logic signed [cnc_pkg::COORD_W-1:0]  nbr_y;
  logic signed [cnc_pkg::COORD_W-1:0]  nbr_z;
  logic        [cnc_pkg::TYPE_W-1:0]   nbr_type;
  logic        [cnc_pkg::MASK_W-1:0]   center_mask;
  logic        [cnc_pkg::MASK_W-1:0]   nbr_mask;
  logic                                pair_valid;
  logic                                last_pair;

  modport source (output valid, center_x, center_y, center_z, nbr_x, nbr_y, nbr_z,
                  nbr_type, center_mask, nbr_mask, pair_valid, last_pair,
                  input ready);
  modport sink (input valid, center_x, center_y, center_z, nbr_x, nbr_y, nbr_z,
                nbr_type, center_mask, nbr_mask, pair_valid, last_pair,
                output ready);
endinterface

@@ rtl/core/cnc_out_if.sv @@
// Result channel of the coordination number counter: one column count per transaction.
// Depends on cnc_pkg for field widths.
interface cnc_out_if;
  logic                             valid;
  logic                             ready;
  logic [cnc_pkg::COL_W-1:0]        column_index;
  logic [cnc_pkg::OCOUNT_W-1:0]     coord_count;
  logic                             last_column;

  modport source (output valid, column_index, coord_count, last_column, input ready);
  modport sink (input valid, column_index, coord_count, last_column, output ready);
endinterface

@@ rtl/core/cnc_cfg_if.sv @@
// Register write channel of the coordination number counter.
// Depends on cnc_pkg for index and data widths.
interface cnc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cnc_pkg::CFG_IDX_W-1:0]      index;
  logic [cnc_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/cnc_front.sv @@
// Front end: accepts pairs, forms squared distance over two register stages and
// classifies each pair into a column hit vector. Depends on cnc_pkg, cnc_in_if.
module cnc_front #(
  parameter int MAX_COLUMNS = cnc_pkg::MAX_COLUMNS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cnc_in_if.sink                     in_ch,
  input  cnc_pkg::cfg_t              cfg,
  input  logic [cnc_pkg::QCNT_W-1:0] q_count,
  output logic                       push,
  output cnc_pkg::pair_ent_t         push_ent
);

  localparam int DW = cnc_pkg::DELTA_W;
  localparam int SW = cnc_pkg::SQ_W;
  localparam int CW = cnc_pkg::CUTOFF_W;

  logic [cnc_pkg::NCOL_W-1:0] ncol;
  logic [cnc_pkg::QCNT_W:0]   occupancy;
  logic                       accept;
  logic                       center_ok;
  logic                       nbr_ok;
  logic [cnc_pkg::HIT_W-1:0]  type_hits;
  logic [CW-1:0]              rsq;

  // Stage 1
  logic                       v1_r;
  logic signed [DW-1:0]       dx_r, dy_r, dz_r;
  logic [cnc_pkg::HIT_W-1:0]  hit1_r;
  logic                       last1_r;
  // Stage 2
  logic                       v2_r;
  logic signed [SW-1:0]       sqx_r, sqy_r, sqz_r;
  logic [cnc_pkg::HIT_W-1:0]  hit2_r;
  logic                       last2_r;

  assign ncol = cnc_pkg::active_cols(cfg.num_columns, MAX_COLUMNS);

  // Credit check: everything in flight must find room in the queue
  assign occupancy = {1'b0, q_count} + (cnc_pkg::QCNT_W+1)'(v1_r)
                     + (cnc_pkg::QCNT_W+1)'(v2_r);
  assign in_ch.ready = occupancy < (cnc_pkg::QCNT_W+1)'(cnc_pkg::QDEPTH);
  assign accept = in_ch.valid && in_ch.ready;

  assign center_ok = (in_ch.center_mask & cfg.center_group_bits) != '0;
  assign nbr_ok = (ncol != cnc_pkg::NCOL_W'(1))
                  || ((in_ch.nbr_mask & cfg.neighbor_group_bits) != '0);

  always_comb begin
    type_hits = '0;
    for (int m = 0; m < MAX_COLUMNS; m++) begin
      type_hits[m] = (cnc_pkg::NCOL_W'(m) < ncol)
                     && (in_ch.nbr_type >= cfg.type_lo_pack[8*m +: 8])
                     && (in_ch.nbr_type <= cfg.type_hi_pack[8*m +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r    <= {in_ch.center_x[cnc_pkg::COORD_W-1], in_ch.center_x}
               - {in_ch.nbr_x[cnc_pkg::COORD_W-1], in_ch.nbr_x};
    dy_r    <= {in_ch.center_y[cnc_pkg::COORD_W-1], in_ch.center_y}
               - {in_ch.nbr_y[cnc_pkg::COORD_W-1], in_ch.nbr_y};
    dz_r    <= {in_ch.center_z[cnc_pkg::COORD_W-1], in_ch.center_z}
               - {in_ch.nbr_z[cnc_pkg::COORD_W-1], in_ch.nbr_z};
    hit1_r  <= (in_ch.pair_valid && center_ok && nbr_ok) ? type_hits : '0;
    last1_r <= in_ch.last_pair;
    sqx_r   <= dx_r * dx_r;
    sqy_r   <= dy_r * dy_r;
    sqz_r   <= dz_r * dz_r;
    hit2_r  <= hit1_r;
    last2_r <= last1_r;
  end

  // Squares are non-negative and below 2^49, so the sum fits the cutoff width
  assign rsq = CW'(unsigned'(sqx_r)) + CW'(unsigned'(sqy_r)) + CW'(unsigned'(sqz_r));

  assign push = v2_r;
  assign push_ent.hits = (rsq < cfg.cutoff_sq) ? hit2_r : '0;
  assign push_ent.last = last2_r;

endmodule

@@ rtl/core/cnc_queue.sv @@
// Short queue of classified pairs between the front and back ends.
// Depends on cnc_pkg for the entry type and depth.
module cnc_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  cnc_pkg::pair_ent_t         push_ent,
  input  logic                       pop,
  output logic                       q_valid,
  output cnc_pkg::pair_ent_t         q_ent,
  output logic [cnc_pkg::QCNT_W-1:0] q_count
);

  cnc_pkg::pair_ent_t               mem_r [cnc_pkg::QDEPTH];
  logic [cnc_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [cnc_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [cnc_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             do_pop;

  assign q_valid = count_r != '0;
  assign q_ent   = mem_r[rd_ptr_r];
  assign q_count = count_r;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + cnc_pkg::QCNT_W'(push) - cnc_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

@@ rtl/core/cnc_back.sv @@
// Back end: applies column hits to the saturating counts and, on the last pair of
// an atom, streams one result per column. Depends on cnc_pkg, cnc_out_if.
module cnc_back #(
  parameter int MAX_COLUMNS = cnc_pkg::MAX_COLUMNS_DEF,
  parameter int COUNT_BITS  = cnc_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cnc_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  cnc_pkg::pair_ent_t q_ent,
  output logic               pop,
  cnc_out_if.source          out_ch
);

  localparam int CNT_W = (COUNT_BITS > cnc_pkg::OCOUNT_W) ? cnc_pkg::OCOUNT_W : COUNT_BITS;
  localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam logic [CNT_W-1:0] CNT_LIM = '1;

  logic [CNT_W-1:0]             counts_r   [MAX_COLUMNS];
  logic [CNT_W-1:0]             counts_nxt [MAX_COLUMNS];
  logic [CNT_W-1:0]             base       [MAX_COLUMNS];
  logic                         emit_r, emit_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [cnc_pkg::NCOL_W-1:0]   ncol;
  logic [IDX_W-1:0]             last_idx;
  logic                         out_free;
  logic                         emit_fire;
  logic                         final_fire;
  logic                         out_valid_r;
  logic [cnc_pkg::COL_W-1:0]    out_col_r;
  logic [cnc_pkg::OCOUNT_W-1:0] out_cnt_r;
  logic                         out_last_r;

  assign ncol       = cnc_pkg::active_cols(cfg.num_columns, MAX_COLUMNS);
  assign last_idx   = IDX_W'(ncol - cnc_pkg::NCOL_W'(1));
  assign out_free   = !out_valid_r || out_ch.ready;
  assign emit_fire  = emit_r && out_free;
  assign final_fire = emit_fire && (idx_r == last_idx);
  // Take the next pair while idle, or in the cycle the final column leaves
  assign pop        = q_valid && (!emit_r || final_fire);

  always_comb begin
    for (int m = 0; m < MAX_COLUMNS; m++) begin
      base[m] = final_fire ? '0 : counts_r[m];
      counts_nxt[m] = base[m];
      if (pop && q_ent.hits[m] && (base[m] != CNT_LIM)) begin
        counts_nxt[m] = base[m] + 1'b1;
      end
    end
    emit_nxt = emit_r;
    idx_nxt  = idx_r;
    if (emit_fire) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (final_fire) begin
      emit_nxt = 1'b0;
    end
    if (pop && q_ent.last) begin
      emit_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int m = 0; m < MAX_COLUMNS; m++) begin
        counts_r[m] <= '0;
      end
    end else begin
      emit_r <= emit_nxt;
      idx_r  <= idx_nxt;
      for (int m = 0; m < MAX_COLUMNS; m++) begin
        counts_r[m] <= counts_nxt[m];
      end
      if (out_free) begin
        out_valid_r <= emit_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_col_r  <= cnc_pkg::COL_W'(idx_r);
      out_cnt_r  <= cnc_pkg::OCOUNT_W'(counts_r[idx_r]);
      out_last_r <= final_fire;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.column_index = out_col_r;
  assign out_ch.coord_count  = out_cnt_r;
  assign out_ch.last_column  = out_last_r;

endmodule

@@ rtl/core/coordination_number_counter.sv @@
// Coordination number counter, top level: configuration registers, front end,
// pair queue and back end. Depends on cnc_pkg, the channel interfaces and cnc_*.
//
// Usage: in_ch carries one neighbor pair per transaction, pairs of one center
// atom grouped and closed by last_pair. For each atom, out_ch gives one
// transaction per column in use (column 0 first), last_column set on the final
// one. cfg_ch writes a register (index 0..5); it is always ready.
// Write registers only while no pair is in flight.
// Throughput: one pair per cycle while in_ch.ready is high; a closing pair also
// holds the back end, which takes no new pair while the counts stream out.
// A pair is classified after two register stages (deltas, then squares) and
// written to the queue; the back end takes it from there, and after a closing
// pair each result passes through the emit state and the output register.
// Reset clears counts, queue and pipeline and loads the register defaults.
// A stalled receiver holds the result register; the back end then stops and
// the queue fills, after which in_ch.ready drops until room returns.
module coordination_number_counter #(
  parameter int MAX_COLUMNS = cnc_pkg::MAX_COLUMNS_DEF,
  parameter int COUNT_BITS  = cnc_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cnc_in_if.sink     in_ch,
  cnc_out_if.source  out_ch,
  cnc_cfg_if.sink    cfg_ch
);

  cnc_pkg::cfg_t                cfg_r;
  cnc_pkg::pair_ent_t           push_ent;
  cnc_pkg::pair_ent_t           q_ent;
  logic                         push;
  logic                         pop;
  logic                         q_valid;
  logic [cnc_pkg::QCNT_W-1:0]   q_count;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutoff_sq           <= '0;
      cfg_r.num_columns         <= cnc_pkg::NCOL_W'(1);
      cfg_r.type_lo_pack        <= '0;
      cfg_r.type_hi_pack        <= '0;
      cfg_r.center_group_bits   <= cnc_pkg::MASK_W'(1);
      cfg_r.neighbor_group_bits <= cnc_pkg::MASK_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        cnc_pkg::REG_CUTOFF_SQ: begin
          cfg_r.cutoff_sq <= cfg_ch.data[cnc_pkg::CUTOFF_W-1:0];
        end
        cnc_pkg::REG_NUM_COLUMNS: begin
          cfg_r.num_columns <= cfg_ch.data[cnc_pkg::NCOL_W-1:0];
        end
        cnc_pkg::REG_TYPE_LO: begin
          cfg_r.type_lo_pack <= cfg_ch.data;
        end
        cnc_pkg::REG_TYPE_HI: begin
          cfg_r.type_hi_pack <= cfg_ch.data;
        end
        cnc_pkg::REG_CENTER_GRP: begin
          cfg_r.center_group_bits <= cfg_ch.data[cnc_pkg::MASK_W-1:0];
        end
        cnc_pkg::REG_NBR_GRP: begin
          cfg_r.neighbor_group_bits <= cfg_ch.data[cnc_pkg::MASK_W-1:0];
        end
        default: begin
          // drop writes outside the register list
        end
      endcase
    end
  end

  cnc_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .q_count  (q_count),
    .push     (push),
    .push_ent (push_ent)
  );

  cnc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_ent    (q_ent),
    .q_count  (q_count)
  );

  cnc_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_ent   (q_ent),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for coordination_number_counter: a scoreboard class
// predicts per-column neighbor counts from each accepted pair and checks every result.
// Depends on cnc_pkg, cnc_in_if, cnc_out_if, cnc_cfg_if and the counter RTL.
module tb;
  import cnc_pkg::*;

  localparam int     MAX_COLS     = MAX_COLUMNS_DEF;
  localparam longint RAW_LIMIT    = (longint'(1) << COUNT_BITS_DEF) - 1;
  localparam int     COUNT_LIMIT  = (RAW_LIMIT > 65535) ? 65535 : int'(RAW_LIMIT);
  localparam int     DRAIN_CYCLES = 16;

  typedef enum {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic signed [COORD_W-1:0] nx, ny, nz;
    logic [TYPE_W-1:0]         ntype;
    logic [MASK_W-1:0]         cmask;
    logic [MASK_W-1:0]         nmask;
    logic                      is_pair;
    logic                      is_last;
  } pair_t;

  typedef struct packed {
    logic [COL_W-1:0]    column;
    logic [OCOUNT_W-1:0] count;
    logic                final_col;
  } col_count_t;

  class coord_scoreboard;
    logic [CUTOFF_W-1:0] cutoff_sq;
    logic [NCOL_W-1:0]   ncol_reg;
    logic [63:0]         lo_pack;
    logic [63:0]         hi_pack;
    logic [MASK_W-1:0]   center_grp;
    logic [MASK_W-1:0]   nbr_grp;
    int unsigned         tally[MAX_COLS];
    col_count_t          awaited[$];
    int                  errors;

    function new();
      cutoff_sq  = '0;
      ncol_reg   = NCOL_W'(1);
      lo_pack    = '0;
      hi_pack    = '0;
      center_grp = MASK_W'(1);
      nbr_grp    = MASK_W'(1);
      foreach (tally[m]) tally[m] = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CUTOFF_SQ:   cutoff_sq  = data[CUTOFF_W-1:0];
        REG_NUM_COLUMNS: ncol_reg   = data[NCOL_W-1:0];
        REG_TYPE_LO:     lo_pack    = data;
        REG_TYPE_HI:     hi_pack    = data;
        REG_CENTER_GRP:  center_grp = data[MASK_W-1:0];
        REG_NBR_GRP:     nbr_grp    = data[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    function longint sq_diff(logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
    endfunction

    function void note_pair(pair_t p);
      int         used;
      longint     rsq;
      bit         nbr_ok;
      logic [7:0] lo, hi;
      col_count_t r;
      used = (ncol_reg == 0) ? 1 : ((ncol_reg > MAX_COLS) ? MAX_COLS : int'(ncol_reg));
      if (p.is_pair && (p.cmask & center_grp) != 0) begin
        // neighbor group only matters with a single column
        nbr_ok = (used != 1) || ((p.nmask & nbr_grp) != 0);
        rsq = sq_diff(p.cx, p.nx) + sq_diff(p.cy, p.ny) + sq_diff(p.cz, p.nz);
        if (nbr_ok && rsq < longint'(cutoff_sq)) begin
          for (int m = 0; m < used; m++) begin
            lo = lo_pack[8*m +: 8];
            hi = hi_pack[8*m +: 8];
            if (p.ntype >= lo && p.ntype <= hi && tally[m] < COUNT_LIMIT) tally[m]++;
          end
        end
      end
      if (p.is_last) begin
        for (int m = 0; m < used; m++) begin
          r.column    = COL_W'(m);
          r.count     = OCOUNT_W'(tally[m]);
          r.final_col = (m + 1 == used);
          awaited.push_back(r);
        end
        foreach (tally[m]) tally[m] = 0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(col_count_t got);
      col_count_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result column %0d count %0d", got.column, got.count));
      end else begin
        want = awaited.pop_front();
        if (got.column !== want.column)
          report($sformatf("column_index %0d, want %0d", got.column, want.column));
        if (got.count !== want.count)
          report($sformatf("column %0d coord_count %0d, want %0d",
                           want.column, got.count, want.count));
        if (got.final_col !== want.final_col)
          report($sformatf("column %0d last_column %0b, want %0b",
                           want.column, got.final_col, want.final_col));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  cnc_in_if  in_ch();
  cnc_out_if out_ch();
  cnc_cfg_if cfg_ch();

  coordination_number_counter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  coord_scoreboard sb;
  flow_t           flow;
  int              hold_left;
  int              reach;
  int              items_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("coordination_number_counter verification failed");
    $finish;
  end

  // Receiver: long hold-off first, then stall per the current flow mode
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (flow)
          FLOW_RECEIVER_STALL: out_ch.ready <= ($urandom_range(99) >= 84);
          FLOW_BOTH:           out_ch.ready <= ($urandom_range(99) >= 10);
          default:             out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_mon
    col_count_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.column    = out_ch.column_index;
      got.count     = out_ch.coord_count;
      got.final_col = out_ch.last_column;
      sb.check_result(got);
    end
  end

  task write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task send_pair(input pair_t p);
    int gap_pct;
    gap_pct = (flow == FLOW_SENDER_IDLE) ? 84 : ((flow == FLOW_BOTH) ? 10 : 0);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.center_x    <= p.cx;
    in_ch.center_y    <= p.cy;
    in_ch.center_z    <= p.cz;
    in_ch.nbr_x       <= p.nx;
    in_ch.nbr_y       <= p.ny;
    in_ch.nbr_z       <= p.nz;
    in_ch.nbr_type    <= p.ntype;
    in_ch.center_mask <= p.cmask;
    in_ch.nbr_mask    <= p.nmask;
    in_ch.pair_valid  <= p.is_pair;
    in_ch.last_pair   <= p.is_last;
    in_ch.valid       <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_pair(p);
    @(negedge clk);
  endtask

  // Stop offering and let every expected count come out
  task wait_drain();
    in_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function pair_t pair_at(int cx, int cy, int cz, int nx, int ny, int nz, int t,
                          logic [MASK_W-1:0] cm, logic [MASK_W-1:0] nm, bit v, bit l);
    pair_t p;
    p.cx = COORD_W'(cx); p.cy = COORD_W'(cy); p.cz = COORD_W'(cz);
    p.nx = COORD_W'(nx); p.ny = COORD_W'(ny); p.nz = COORD_W'(nz);
    p.ntype = TYPE_W'(t);
    p.cmask = cm;
    p.nmask = nm;
    p.is_pair = v;
    p.is_last = l;
    return p;
  endfunction

  // One center atom: neighbors scattered around it within the phase reach
  task send_atom(input int len, input bit noisy);
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic [MASK_W-1:0]         cm;
    pair_t                     p;
    int                        off;
    cx = COORD_W'($urandom);
    cy = COORD_W'($urandom);
    cz = COORD_W'($urandom);
    cm = $urandom;
    if ($urandom_range(9) == 0) cm &= ~sb.center_grp;
    for (int k = 0; k < len; k++) begin
      p.cx = cx; p.cy = cy; p.cz = cz;
      off = int'($urandom_range(0, 2 * reach)) - reach;
      p.nx = cx + COORD_W'(off);
      off = int'($urandom_range(0, 2 * reach)) - reach;
      p.ny = cy + COORD_W'(off);
      off = int'($urandom_range(0, 2 * reach)) - reach;
      p.nz = cz + COORD_W'(off);
      p.cmask = cm;
      p.nmask = $urandom;
      if ($urandom_range(4) == 0) p.nmask &= ~sb.nbr_grp;
      p.is_pair = ($urandom_range(19) != 0);
      if ($urandom_range(4) == 0) p.ntype = $urandom_range(1) ? 8'd255 : 8'd1;
      else p.ntype = TYPE_W'($urandom_range(1, 255));
      if (noisy) begin
        p.cmask   = $urandom;
        p.nx      = COORD_W'($urandom);
        p.ny      = COORD_W'($urandom);
        p.nz      = COORD_W'($urandom);
        p.is_pair = 1'($urandom_range(1));
      end
      p.is_last = (k == len - 1);
      send_pair(p);
      items_sent++;
    end
  endtask

  task set_phase_config(input int ph);
    logic [NCOL_W-1:0]   ncol_pick[8];
    logic [CUTOFF_W-1:0] cutoff;
    logic [63:0]         lo, hi;
    logic [MASK_W-1:0]   cgrp, ngrp;
    int                  a, b;
    ncol_pick = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd2, 4'd1, 4'd9};
    case ($urandom_range(2))
      0:       reach = $urandom_range(1, 64);
      1:       reach = $urandom_range(256, 65535);
      default: reach = $urandom_range(1 << 20, 1 << 23);
    endcase
    cutoff = CUTOFF_W'(longint'(reach) * reach * $urandom_range(1, 3));
    if (ph == 3) cutoff = '0;
    if (ph == 4) cutoff = '1;
    for (int m = 0; m < MAX_COLS; m++) begin
      case ($urandom_range(3))
        0: begin a = $urandom_range(1); b = 255; end
        1: begin a = $urandom_range(1, 200); b = a + $urandom_range(0, 55); end
        2: begin a = $urandom_range(2, 255); b = $urandom_range(0, a - 1); end
        default: begin a = $urandom_range(255); b = $urandom_range(255); end
      endcase
      lo[8*m +: 8] = 8'(a);
      hi[8*m +: 8] = 8'(b);
    end
    cgrp = $urandom;
    ngrp = 32'h1 << $urandom_range(31);
    if (ph == 3) cgrp = '0;
    if (ph == 6) begin cgrp = '1; ngrp = '1; end
    if (ph == 7) cgrp = 32'h1;
    if (ph == 2) ngrp = '0;
    // upper data bits beyond each register's width are junk on purpose
    write_cfg(REG_CUTOFF_SQ,   {12'($urandom), cutoff});
    write_cfg(REG_NUM_COLUMNS, {32'($urandom), 28'($urandom), ncol_pick[ph]});
    write_cfg(REG_TYPE_LO,     lo);
    write_cfg(REG_TYPE_HI,     hi);
    write_cfg(REG_CENTER_GRP,  {32'($urandom), cgrp});
    write_cfg(REG_NBR_GRP,     {32'($urandom), ngrp});
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int    phase_start;
    sb = new();
    flow = FLOW_FREE;
    hold_left = 0;
    reach = 1;
    items_sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.center_x = '0; in_ch.center_y = '0; in_ch.center_z = '0;
    in_ch.nbr_x = '0; in_ch.nbr_y = '0; in_ch.nbr_z = '0;
    in_ch.nbr_type = '0; in_ch.center_mask = '0; in_ch.nbr_mask = '0;
    in_ch.pair_valid = 1'b0; in_ch.last_pair = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CUTOFF_SQ;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: zero cutoff, so nothing counts
    send_pair(pair_at(0, 0, 0, 0, 0, 0, 1, '1, '1, 1, 1));
    wait_drain();

    // cutoff distance 256 (squared 65536), single column with neighbor gate
    write_cfg(REG_CUTOFF_SQ,   64'd65536);
    write_cfg(REG_NUM_COLUMNS, 64'd1);
    write_cfg(REG_TYPE_LO,     64'h01);
    write_cfg(REG_TYPE_HI,     64'hFF);
    write_cfg(REG_CENTER_GRP,  64'h1);
    write_cfg(REG_NBR_GRP,     64'h1);
    cfg_ch.valid <= 1'b0;
    send_pair(pair_at(100, 0, 0, 355, 0, 0, 5, 32'h1, 32'h1, 1, 0));  // just inside
    send_pair(pair_at(0, 100, 0, 0, 356, 0, 5, 32'h1, 32'h1, 1, 0));  // on the cutoff
    send_pair(pair_at(7, 7, 7, 7, 7, 7, 255, 32'h1, 32'h1, 1, 0));
    send_pair(pair_at(7, 7, 7, 7, 7, 7, 255, 32'h1, 32'h1, 0, 0));    // no pair
    send_pair(pair_at(7, 7, 7, 7, 7, 7, 1, 32'h1, 32'h2, 1, 0));      // neighbor outside
    send_pair(pair_at(0, 0, -10, 0, 0, -265, 1, 32'h1, 32'h1, 1, 1));
    send_pair(pair_at(0, 0, 0, 0, 0, 0, 9, 32'h2, 32'h1, 1, 0));      // center outside
    send_pair(pair_at(0, 0, 0, 0, 0, 0, 9, 32'h2, 32'h1, 1, 1));
    send_pair(pair_at(0, 0, 0, 0, 0, 0, 9, 32'h1, 32'h1, 0, 1));      // atom with no neighbors
    wait_drain();

    // all eight columns: full, single types, window, empty ranges
    write_cfg(REG_CUTOFF_SQ,   '1);
    write_cfg(REG_NUM_COLUMNS, 64'd8);
    write_cfg(REG_TYPE_LO,     {8'd0, 8'd2, 8'd0, 8'd50, 8'd128, 8'd255, 8'd1, 8'd1});
    write_cfg(REG_TYPE_HI,     {8'd255, 8'd254, 8'd0, 8'd40, 8'd200, 8'd255, 8'd1, 8'd255});
    write_cfg(REG_CENTER_GRP,  64'h8000_0000);
    write_cfg(REG_NBR_GRP,     '1);
    cfg_ch.valid <= 1'b0;
    send_pair(pair_at(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 1,
                      32'h8000_0000, 32'h0, 1, 0));
    send_pair(pair_at(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 255,
                      '1, 32'h0, 1, 0));
    send_pair(pair_at(3, 3, 3, 3, 3, 3, 128, '1, '1, 1, 0));
    send_pair(pair_at(3, 3, 3, 3, 3, 3, 200, '1, '1, 1, 0));
    send_pair(pair_at(3, 3, 3, 3, 3, 3, 50, '1, '1, 1, 1));
    wait_drain();
    write_cfg(REG_NUM_COLUMNS, 64'd0);  // acts as one column
    cfg_ch.valid <= 1'b0;
    send_pair(pair_at(1, 2, 3, 4, 5, 6, 77, '1, '1, 1, 0));
    send_pair(pair_at(1, 2, 3, 4, 5, 6, 77, '1, '1, 1, 1));
    wait_drain();
    write_cfg(REG_NUM_COLUMNS, 64'd15); // clipped to the maximum
    cfg_ch.valid <= 1'b0;
    send_pair(pair_at(1, 2, 3, 4, 5, 6, 1, '1, '1, 1, 0));
    send_pair(pair_at(1, 2, 3, 4, 5, 6, 255, '1, '1, 1, 1));
    wait_drain();

    for (int ph = 0; ph < 8; ph++) begin
      flow = flow_t'(ph % 4);
      set_phase_config(ph);
      phase_start = items_sent;
      if (ph == 1) begin
        // hold results back while short atoms keep coming, so the input stalls
        hold_left = 400;
        while (items_sent - phase_start < 25) send_atom($urandom_range(1, 2), 1'b0);
      end
      while (items_sent - phase_start < 10) begin
        if (ph == 5 && items_sent - phase_start >= 7 && items_sent - phase_start < 10)
          wait_drain();
        send_atom($urandom_range(1, 5), $urandom_range(4) == 0);
      end
      wait_drain();
    end

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("coordination_number_counter verification clean");
    end else begin
      $display("coordination_number_counter verification failed");
    end
    $finish;
  end
endmodule
